// ===== src/tpcd_pkg.sv =====
// Shared types, constants and decode functions of the tracker pattern cell decoder.
`timescale 1ns / 1ps
package tpcd_pkg;

  // Pattern geometry used for the position check
  localparam int LINES_PER_PATTERN = 64;
  localparam int CHANNELS          = 9;
  localparam logic [7:0] LINE_LIMIT = 8'(LINES_PER_PATTERN);
  localparam logic [7:0] CHAN_LIMIT = 8'(CHANNELS);

  // Cell queue between parser and decoder
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // Note remap constants
  localparam logic [6:0] NOTE_KEY_OFF_IN = 7'd15;
  localparam logic [6:0] NOTE_KEY_OFF    = 7'd127;
  localparam logic [6:0] NOTE_OCT_LOW    = 7'd16;
  localparam logic [6:0] NOTE_NO_INC     = 7'd126;

  // Divide by ten: x / 10 == (x * 205) >> 11 for every 8-bit x
  localparam logic [7:0] DIV10_MUL   = 8'd205;
  localparam int         DIV10_SHIFT = 11;
  localparam logic [3:0] TEN         = 4'd10;

  // Parser phases
  typedef enum logic [2:0] {
    PH_LINE  = 3'd0,
    PH_CHAN  = 3'd1,
    PH_NOTE  = 3'd2,
    PH_INSFX = 3'd3,
    PH_PARAM = 3'd4
  } phase_t;

  // Raw cell as gathered by the parser
  typedef struct packed {
    logic [6:0] line;
    logic [6:0] channel;
    logic [6:0] note;
    logic [4:0] instrument;
    logic [3:0] effect;
    logic [7:0] param;
    logic       has_param;
    logic       line_last;
    logic       chan_last;
  } cell_t;

  // Effect translation table
  function automatic logic [7:0] fx_xlate(input logic [3:0] fx);
    logic [7:0] r;
    case (fx)
      4'd1:    r = 8'd1;
      4'd2:    r = 8'd2;
      4'd3:    r = 8'd3;
      4'd5:    r = 8'd5;
      4'd10:   r = 8'd20;
      4'd12:   r = 8'd17;
      4'd13:   r = 8'h0d;
      4'd15:   r = 8'd19;
      default: r = 8'd255;
    endcase
    return r;
  endfunction

  // Map packed note to linear form; key off becomes 127
  function automatic logic [6:0] remap_note(input logic [6:0] n_in);
    logic [6:0] n;
    n = n_in;
    if (n == NOTE_KEY_OFF_IN) begin
      n = NOTE_KEY_OFF;
    end
    if (n > NOTE_OCT_LOW && n < NOTE_KEY_OFF) begin
      n = n - 7'({n[6:4], 2'b00});
    end
    if (n != 7'd0 && n < NOTE_NO_INC) begin
      n = n + 7'd1;
    end
    return n;
  endfunction

endpackage

// ===== src/tpcd_if.sv =====
// Valid/ready channel interfaces for pattern bytes and decoded cells.
`timescale 1ns / 1ps
interface tpcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       start_of_pattern;
  modport source (output valid, output byte_value, output start_of_pattern, input ready);
  modport sink   (input valid, input byte_value, input start_of_pattern, output ready);
endinterface

interface tpcd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] line_number;
  logic [6:0] channel_number;
  logic [6:0] note_code;
  logic [4:0] instrument_number;
  logic [7:0] effect_code;
  logic [4:0] param_tens;
  logic [3:0] param_units;
  logic       last_in_pattern;
  logic       bad_position;
  modport source (
    output valid, output line_number, output channel_number, output note_code,
    output instrument_number, output effect_code, output param_tens,
    output param_units, output last_in_pattern, output bad_position, input ready
  );
  modport sink (
    input valid, input line_number, input channel_number, input note_code,
    input instrument_number, input effect_code, input param_tens,
    input param_units, input last_in_pattern, input bad_position, output ready
  );
endinterface

// ===== src/tracker_pattern_cell_decoder_top.sv =====
// Top level of the tracker pattern cell decoder: parser, cell queue, decoder.
//
//   channel  dir  handshake        beat contents
//   in_ch    in   valid/ready      byte_value, start_of_pattern
//   out_ch   out  valid/ready      line, channel, note, instrument, effect,
//                                  param tens/units, last/bad flags
//
// One byte per cycle is taken while the four-entry cell queue has room.
// A cell is in the output register in the cycle after it is dequeued; the
// decode stage pops one cell per cycle while out_ch takes beats.
// Reset (rst_n low, synchronous) puts the parser in the line-byte phase
// and empties queue and output register.
// A stall on out_ch backs up the queue; in_ch.ready drops only when it is full.
`timescale 1ns / 1ps
module tracker_pattern_cell_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  tpcd_in_if.sink     in_ch,
  tpcd_out_if.source  out_ch
);

  logic            q_push, q_pop, q_full, q_not_empty;
  tpcd_pkg::cell_t push_cell, head_cell;

  tpcd_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_cell (push_cell)
  );

  tpcd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cell (push_cell),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head_cell (head_cell)
  );

  tpcd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_not_empty),
    .q_cell  (head_cell),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

  // A start-of-pattern byte is always a line byte and never ends a cell
  a_start_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.start_of_pattern) |-> !q_push)
    else $error("cell pushed on start-of-pattern byte");

  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full cell queue");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("pop from empty cell queue");

  // A new output beat appears only after a dequeue
  a_out_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_ch.valid) |-> $past(q_pop))
    else $error("output beat without dequeue");

endmodule

// ===== src/tpcd_front.sv =====
// Byte parser: walks the packed stream and pushes each completed raw cell.
`timescale 1ns / 1ps
module tpcd_front (
  input  logic           clk,
  input  logic           rst_n,
  tpcd_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           q_push,
  output tpcd_pkg::cell_t q_cell
);

  tpcd_pkg::phase_t phase_r, phase_nxt, eff_phase;
  logic [6:0] line_r, line_nxt;
  logic [6:0] chan_r, chan_nxt;
  logic       line_last_r, line_last_nxt;
  logic       chan_last_r, chan_last_nxt;
  logic [6:0] note_r, note_nxt;
  logic [4:0] inst_r, inst_nxt;
  logic [3:0] fx_r, fx_nxt;
  logic       take;
  logic [7:0] b;
  logic [4:0] inst_sum;

  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;
  assign b           = in_ch.byte_value;
  assign eff_phase   = in_ch.start_of_pattern ? tpcd_pkg::PH_LINE : phase_r;
  assign inst_sum    = inst_r + {1'b0, b[7:4]};

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    if (take) begin
      case (eff_phase)
        tpcd_pkg::PH_CHAN:  phase_nxt = tpcd_pkg::PH_NOTE;
        tpcd_pkg::PH_NOTE:  phase_nxt = tpcd_pkg::PH_INSFX;
        tpcd_pkg::PH_INSFX: begin
          if (b[3:0] != 4'd0) begin
            phase_nxt = tpcd_pkg::PH_PARAM;
          end else begin
            phase_nxt = chan_last_r ? tpcd_pkg::PH_LINE : tpcd_pkg::PH_CHAN;
          end
        end
        tpcd_pkg::PH_PARAM: phase_nxt = chan_last_r ? tpcd_pkg::PH_LINE : tpcd_pkg::PH_CHAN;
        default:            phase_nxt = tpcd_pkg::PH_CHAN;
      endcase
    end
  end

  // Field capture and cell push
  always_comb begin
    line_nxt      = line_r;
    chan_nxt      = chan_r;
    line_last_nxt = line_last_r;
    chan_last_nxt = chan_last_r;
    note_nxt      = note_r;
    inst_nxt      = inst_r;
    fx_nxt        = fx_r;
    q_push        = 1'b0;
    q_cell.line       = line_r;
    q_cell.channel    = chan_r;
    q_cell.note       = note_r;
    q_cell.instrument = inst_r;
    q_cell.effect     = fx_r;
    q_cell.param      = b;
    q_cell.has_param  = 1'b1;
    q_cell.line_last  = line_last_r;
    q_cell.chan_last  = chan_last_r;
    if (take) begin
      case (eff_phase)
        tpcd_pkg::PH_CHAN: begin
          chan_nxt      = b[6:0];
          chan_last_nxt = b[7];
        end
        tpcd_pkg::PH_NOTE: begin
          note_nxt = b[6:0];
          inst_nxt = {b[7], 4'd0};
        end
        tpcd_pkg::PH_INSFX: begin
          inst_nxt = inst_sum;
          fx_nxt   = b[3:0];
          // No parameter follows a zero effect: the cell ends here
          q_cell.instrument = inst_sum;
          q_cell.effect     = b[3:0];
          q_cell.param      = 8'd0;
          q_cell.has_param  = 1'b0;
          q_push            = (b[3:0] == 4'd0);
        end
        tpcd_pkg::PH_PARAM: begin
          q_push = 1'b1;
        end
        default: begin
          line_nxt      = b[6:0];
          line_last_nxt = b[7];
        end
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= tpcd_pkg::PH_LINE;
      line_r      <= 7'd0;
      chan_r      <= 7'd0;
      line_last_r <= 1'b0;
      chan_last_r <= 1'b0;
      note_r      <= 7'd0;
      inst_r      <= 5'd0;
      fx_r        <= 4'd0;
    end else begin
      phase_r     <= phase_nxt;
      line_r      <= line_nxt;
      chan_r      <= chan_nxt;
      line_last_r <= line_last_nxt;
      chan_last_r <= chan_last_nxt;
      note_r      <= note_nxt;
      inst_r      <= inst_nxt;
      fx_r        <= fx_nxt;
    end
  end

endmodule

// ===== src/tpcd_queue.sv =====
// Short cell queue between parser and decoder.
`timescale 1ns / 1ps
module tpcd_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  tpcd_pkg::cell_t push_cell,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output tpcd_pkg::cell_t head_cell
);

  tpcd_pkg::cell_t mem_r [tpcd_pkg::QDEPTH];
  logic [tpcd_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [tpcd_pkg::QCNT_W-1:0] count_r;

  assign full      = (count_r == tpcd_pkg::QCNT_W'(tpcd_pkg::QDEPTH));
  assign not_empty = (count_r != '0);
  assign head_cell = mem_r[rd_ptr_r];

  // Store entry
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cell;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + tpcd_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + tpcd_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + tpcd_pkg::QCNT_W'(1);
        2'b01:   count_r <= count_r - tpcd_pkg::QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== src/tpcd_back.sv =====
// Cell decoder: remaps note and effect, splits the parameter, holds the output beat.
`timescale 1ns / 1ps
module tpcd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_valid,
  input  tpcd_pkg::cell_t q_cell,
  output logic            q_pop,
  tpcd_out_if.source      out_ch
);

  logic        valid_r;
  logic [15:0] prod;
  logic [4:0]  tens;
  logic [7:0]  tens_x10;
  logic [7:0]  units;
  logic        bad;

  logic [6:0] line_r, chan_r, note_r;
  logic [4:0] inst_r, tens_r;
  logic [7:0] fx_r;
  logic [3:0] units_r;
  logic       last_r, bad_r;

  assign q_pop = q_valid && (!valid_r || out_ch.ready);

  // Split parameter into tens and units by reciprocal multiply; flag out-of-range positions
  always_comb begin
    prod     = 16'(q_cell.param) * 16'(tpcd_pkg::DIV10_MUL);
    tens     = prod[tpcd_pkg::DIV10_SHIFT +: 5];
    tens_x10 = 8'(tens) * 8'(tpcd_pkg::TEN);
    units    = q_cell.param - tens_x10;
    bad      = ({1'b0, q_cell.line} >= tpcd_pkg::LINE_LIMIT)
            || ({1'b0, q_cell.channel} >= tpcd_pkg::CHAN_LIMIT);
  end

  // Output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Load output payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      line_r  <= q_cell.line;
      chan_r  <= q_cell.channel;
      note_r  <= tpcd_pkg::remap_note(q_cell.note);
      inst_r  <= q_cell.instrument;
      fx_r    <= tpcd_pkg::fx_xlate(q_cell.effect);
      tens_r  <= q_cell.has_param ? tens : 5'd0;
      units_r <= q_cell.has_param ? units[3:0] : 4'd0;
      last_r  <= q_cell.line_last && q_cell.chan_last;
      bad_r   <= bad;
    end
  end

  assign out_ch.valid             = valid_r;
  assign out_ch.line_number       = line_r;
  assign out_ch.channel_number    = chan_r;
  assign out_ch.note_code         = note_r;
  assign out_ch.instrument_number = inst_r;
  assign out_ch.effect_code       = fx_r;
  assign out_ch.param_tens        = tens_r;
  assign out_ch.param_units       = units_r;
  assign out_ch.last_in_pattern   = last_r;
  assign out_ch.bad_position      = bad_r;

endmodule
